// ===== rtl/core/three_wheel_vector_average_top_macros.svh =====
// Assertion macros for the wheel vector averager.
`ifndef THREE_WHEEL_VECTOR_AVERAGE_TOP_MACROS_SVH
`define THREE_WHEEL_VECTOR_AVERAGE_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define TWVA_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TWVA_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/twva_pkg.sv =====
// ----------------------------------------------------------------------------
// twva_pkg
// Shared widths, constants and the arctangent table.
// ----------------------------------------------------------------------------
package twva_pkg;
    localparam int ANG_W   = 16;
    localparam int SPD_W   = 16;
    localparam int HDG_W   = 15;
    localparam int MAG_W   = 16;
    localparam int VEC_W   = 30;
    localparam int ZW      = 24;
    localparam int TABLE_LEN = 24;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam logic signed [ANG_W-1:0] ANG_SAT = 16'sd25736;
    localparam logic signed [ZW-1:0] PI_INT = 24'sd3294199;
    localparam logic signed [ZW-1:0] HALF_PI_INT = 24'sd1647099;
    localparam logic [29:0] KSQ_Q30 = 30'd395948846;
    localparam int HDG_MAX = 11520;
    localparam int MAG_MAX = 32768;

    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic signed [ZW-1:0] t_ang;

    typedef struct packed {
        t_vec x;
        t_vec y;
    } t_xy;

    function automatic t_ang atan_tab(input int i);
        case (i)
            0: atan_tab = 24'sd823550;
            1: atan_tab = 24'sd486170;
            2: atan_tab = 24'sd256879;
            3: atan_tab = 24'sd130396;
            4: atan_tab = 24'sd65451;
            5: atan_tab = 24'sd32757;
            6: atan_tab = 24'sd16383;
            7: atan_tab = 24'sd8192;
            8: atan_tab = 24'sd4096;
            9: atan_tab = 24'sd2048;
            10: atan_tab = 24'sd1024;
            11: atan_tab = 24'sd512;
            12: atan_tab = 24'sd256;
            13: atan_tab = 24'sd128;
            14: atan_tab = 24'sd64;
            15: atan_tab = 24'sd32;
            16: atan_tab = 24'sd16;
            17: atan_tab = 24'sd8;
            18: atan_tab = 24'sd4;
            19: atan_tab = 24'sd2;
            20: atan_tab = 24'sd1;
            21: atan_tab = 24'sd1;
            default: atan_tab = 24'sd0;
        endcase
    endfunction
endpackage

// ===== rtl/core/three_wheel_vector_average_top.sv =====
// Path: rotations, sum, vectoring, stages A-C, queue (CORDIC_STEPS at most 24).
// Throughput: one wheel set per cycle; the pipeline never stalls, push is held
// off (full) once words in flight plus words queued reach the queue depth.
// Reset: synchronous active-low i_rst_n clears valid bits, counts and pointers.
// ----------------------------------------------------------------------------
// three_wheel_vector_average_top
// Mean of three polar wheel vectors as heading and magnitude.
// ----------------------------------------------------------------------------
`include "three_wheel_vector_average_top_macros.svh"
module three_wheel_vector_average_top #(
    parameter int CORDIC_STEPS = twva_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [twva_pkg::ANG_W-1:0] i_left_angle,
    input  logic signed [twva_pkg::SPD_W-1:0] i_left_speed,
    input  logic signed [twva_pkg::ANG_W-1:0] i_right_angle,
    input  logic signed [twva_pkg::SPD_W-1:0] i_right_speed,
    input  logic signed [twva_pkg::ANG_W-1:0] i_back_angle,
    input  logic signed [twva_pkg::SPD_W-1:0] i_back_speed,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [twva_pkg::HDG_W-1:0] o_heading_deg,
    output logic [twva_pkg::MAG_W-1:0]        o_magnitude
);
    import twva_pkg::*;

    localparam int N   = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int LAT = 2 * N + 6;
    // Queue deep enough to hold every word in flight.
    localparam int QD  = LAT + 2;
    localparam int QAW = $clog2(QD);

    logic en;
    logic [LAT-1:0] r_vld;
    t_xy sum;
    logic signed [HDG_W-1:0] hdg;
    logic [MAG_W-1:0] mag;

    // Credit count: words in pipe plus words queued never exceed QD.
    logic [QAW:0] r_cnt, r_inflight;
    logic acc, deq;

    assign en   = 1'b1;
    assign acc  = push && !full;
    assign deq  = pop && !empty;
    assign full = (32'(r_inflight) + 32'(r_cnt)) >= QD;

    twva_front #(.STEPS(CORDIC_STEPS)) u_front (
        .i_clk(i_clk), .i_en(en),
        .i_left_angle(i_left_angle), .i_left_speed(i_left_speed),
        .i_right_angle(i_right_angle), .i_right_speed(i_right_speed),
        .i_back_angle(i_back_angle), .i_back_speed(i_back_speed),
        .o_sum(sum));

    twva_back #(.STEPS(CORDIC_STEPS)) u_back (
        .i_clk(i_clk), .i_en(en), .i_sum(sum),
        .o_heading_deg(hdg), .o_magnitude(mag));

    logic done;
    assign done = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_inflight <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], acc};
            r_inflight <= r_inflight + (QAW+1)'(acc) - (QAW+1)'(done);
        end
    end

    // Result queue with a registered head word.
    logic [HDG_W+MAG_W-1:0] r_mem [QD];
    logic [HDG_W+MAG_W-1:0] r_rdata;
    logic [QAW-1:0] r_wp, r_rp, n_rp;

    always_comb begin
        n_rp = r_rp;
        if (deq) n_rp = (32'(r_rp) == QD - 1) ? '0 : r_rp + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (done) r_mem[r_wp] <= {hdg, mag};
        // Read ahead at the next head slot; forward the word written there now.
        if (done && r_wp == n_rp) r_rdata <= {hdg, mag};
        else r_rdata <= r_mem[n_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (done) r_wp <= (32'(r_wp) == QD - 1) ? '0 : r_wp + 1'b1;
            r_rp <= n_rp;
            r_cnt <= r_cnt + (QAW+1)'(done) - (QAW+1)'(deq);
        end
    end

    assign empty = (r_cnt == '0);
    assign {o_heading_deg, o_magnitude} = r_rdata;

    `TWVA_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, 1'b1, 32'(r_cnt) <= QD)
    `TWVA_ASSERT_NEXT(a_fill, i_clk, i_rst_n, done && !deq, !empty)
    `TWVA_ASSERT_IMPL(a_hdg_rng, i_clk, i_rst_n, !empty,
        o_heading_deg <= 15'sd11520 && o_heading_deg >= -15'sd11520)
endmodule

// ===== rtl/core/twva_rot.sv =====
// ----------------------------------------------------------------------------
// twva_rot
// Pipelined rotation CORDIC: one wheel (angle, speed) to x/y with gain.
// ----------------------------------------------------------------------------
module twva_rot #(
    parameter int STEPS = twva_pkg::CORDIC_STEPS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [twva_pkg::ANG_W-1:0] i_angle,
    input  logic signed [twva_pkg::SPD_W-1:0] i_speed,
    output twva_pkg::t_xy                o_xy
);
    import twva_pkg::*;

    localparam int N = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;

    t_vec r_x [N+1];
    t_vec r_y [N+1];
    t_ang r_z [N+1];

    logic signed [ANG_W-1:0] sat_a;
    t_ang z0;
    t_vec x0;

    always_comb begin
        sat_a = i_angle;
        if (i_angle > ANG_SAT) sat_a = ANG_SAT;
        if (i_angle < -ANG_SAT) sat_a = -ANG_SAT;
        z0 = t_ang'(sat_a) <<< 7;
        x0 = t_vec'(i_speed) <<< 8;
        if (z0 > HALF_PI_INT) begin
            z0 = z0 - PI_INT;
            x0 = -x0;
        end else if (z0 < -HALF_PI_INT) begin
            z0 = z0 + PI_INT;
            x0 = -x0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= x0;
            r_y[0] <= '0;
            r_z[0] <= z0;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[g][ZW-1]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_tab(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_tab(g);
                end
            end
        end
    end

    assign o_xy.x = r_x[N];
    assign o_xy.y = r_y[N];
endmodule

// ===== rtl/core/twva_front.sv =====
// ----------------------------------------------------------------------------
// twva_front
// Three rotation pipelines and the registered sum of their outputs.
// ----------------------------------------------------------------------------
module twva_front #(
    parameter int STEPS = twva_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [twva_pkg::ANG_W-1:0] i_left_angle,
    input  logic signed [twva_pkg::SPD_W-1:0] i_left_speed,
    input  logic signed [twva_pkg::ANG_W-1:0] i_right_angle,
    input  logic signed [twva_pkg::SPD_W-1:0] i_right_speed,
    input  logic signed [twva_pkg::ANG_W-1:0] i_back_angle,
    input  logic signed [twva_pkg::SPD_W-1:0] i_back_speed,
    output twva_pkg::t_xy                     o_sum
);
    import twva_pkg::*;

    t_xy l_xy, r_xy, b_xy;
    t_xy r_sum;

    twva_rot #(.STEPS(STEPS)) u_left (
        .i_clk(i_clk), .i_en(i_en), .i_angle(i_left_angle),
        .i_speed(i_left_speed), .o_xy(l_xy));
    twva_rot #(.STEPS(STEPS)) u_right (
        .i_clk(i_clk), .i_en(i_en), .i_angle(i_right_angle),
        .i_speed(i_right_speed), .o_xy(r_xy));
    twva_rot #(.STEPS(STEPS)) u_back (
        .i_clk(i_clk), .i_en(i_en), .i_angle(i_back_angle),
        .i_speed(i_back_speed), .o_xy(b_xy));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum.x <= l_xy.x + r_xy.x + b_xy.x;
            r_sum.y <= l_xy.y + r_xy.y + b_xy.y;
        end
    end

    assign o_sum = r_sum;
endmodule

// ===== rtl/core/twva_back.sv =====
// ----------------------------------------------------------------------------
// twva_back
// Vectoring CORDIC on the sum, then heading and magnitude scaling.
// ----------------------------------------------------------------------------
module twva_back #(
    parameter int STEPS = twva_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  twva_pkg::t_xy                     i_sum,
    output logic signed [twva_pkg::HDG_W-1:0] o_heading_deg,
    output logic [twva_pkg::MAG_W-1:0]        o_magnitude
);
    import twva_pkg::*;

    localparam int N = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;
    localparam int XW = VEC_W + 2;
    // heading = z*11520/PI: p=z*11520, then *M >> SH reciprocal with correction
    localparam int PW = ZW + 15;
    localparam logic [PW-1:0] PI_U = PW'(3294199);
    // Reciprocal of PI on the numerator with its low 12 bits dropped.
    localparam int HSH = 12;
    localparam logic [PW-HSH-1:0] HREC = (PW-HSH)'((64'd1 << 48) / 64'd3294199);

    logic signed [XW-1:0] r_x [N+1];
    logic signed [XW-1:0] r_y [N+1];
    t_ang r_z [N+1];
    logic r_zero [N+1];

    logic signed [XW-1:0] x0, y0;
    t_ang z0;

    always_comb begin
        x0 = XW'(i_sum.x);
        y0 = XW'(i_sum.y);
        z0 = '0;
        if (x0 < 0) begin
            z0 = (y0 >= 0) ? PI_INT : -PI_INT;
            x0 = -x0;
            y0 = -y0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= x0;
            r_y[0] <= y0;
            r_z[0] <= z0;
            r_zero[0] <= (i_sum.x == '0) && (i_sum.y == '0);
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[g+1] <= r_zero[g];
                if (!r_y[g][XW-1]) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_tab(g);
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_tab(g);
                end
            end
        end
    end

    // Stage A: products. Heading numerator |z|*11520 + PI/2, mag x*KSQ.
    logic [PW-1:0] r_hnum;
    logic          r_hneg;
    logic [61:0]   r_mprod;
    logic          r_zero_a;
    logic [ZW-1:0] zabs;
    logic [XW-2:0] xpos;

    always_comb begin
        zabs = r_z[N][ZW-1] ? ZW'(-r_z[N]) : ZW'(r_z[N]);
        xpos = (r_x[N] > 0) ? r_x[N][XW-2:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hnum   <= PW'(zabs) * PW'(HDG_MAX) + PW'(1647099);
            r_hneg   <= r_z[N][ZW-1];
            r_mprod  <= 62'(xpos[30:0]) * 62'(KSQ_Q30);
            r_zero_a <= r_zero[N];
        end
    end

    // Stage B: heading quotient estimate by reciprocal multiply; the estimate
    // is never above the true quotient and at most one below it.
    logic [2*(PW-HSH)-1:0] hprod;
    logic [14:0] hq;
    logic [63:0] msum;
    logic [25:0] mq;

    always_comb begin
        hprod = (2*(PW-HSH))'(r_hnum[PW-1:HSH]) * (2*(PW-HSH))'(HREC);
        hq = 15'(hprod >> 36);
        // mag = (prod + 3*2^37) / (3*2^38): shift by 38 then divide by 3
        msum = 64'(r_mprod) + (64'd3 << 37);
        mq = 26'(msum >> 38);
    end

    logic [14:0]   r_hq;
    logic [PW-1:0] r_hnum_b;
    logic          r_hneg_b, r_zero_b;
    logic [25:0]   r_mq;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hq <= hq;
            r_hnum_b <= r_hnum;
            r_hneg_b <= r_hneg;
            r_zero_b <= r_zero_a;
            r_mq <= mq;
        end
    end

    // Stage C: heading correction, divide by 3 via reciprocal, clamp.
    logic [PW-1:0] hrem;
    logic [14:0] hqc;
    logic [25:0] m3;
    logic [53:0] mrec;
    logic [14:0] hc;
    logic [16:0] mc;

    always_comb begin
        hrem = r_hnum_b - PW'(r_hq) * PI_U;
        hqc = (hrem >= PI_U) ? r_hq + 15'd1 : r_hq;
        mrec = 54'(r_mq) * 54'd22369622;
        m3 = 26'(mrec >> 26);
        if (26'(m3 * 26'd3) + 26'd3 <= r_mq) m3 = m3 + 26'd1;
        hc = (hqc > 15'(HDG_MAX)) ? 15'(HDG_MAX) : hqc;
        mc = (m3 > 26'(MAG_MAX)) ? 17'(MAG_MAX) : 17'(m3);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_heading_deg <= r_zero_b ? '0 : (r_hneg_b ? -hc : hc);
            o_magnitude   <= r_zero_b ? '0 : mc[MAG_W-1:0];
        end
    end
endmodule

// ===== test/twva_checker.sv =====
// ----------------------------------------------------------------------------
// twva_checker
// Watches both queue ports of the wheel vector averager, works out the
// heading and magnitude of every accepted wheel set and compares each popped
// word with the oldest outstanding one.
// ----------------------------------------------------------------------------
module twva_checker #(
    parameter int CORDIC_STEPS = twva_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic                              i_full,
    input  logic signed [twva_pkg::ANG_W-1:0] i_left_angle,
    input  logic signed [twva_pkg::SPD_W-1:0] i_left_speed,
    input  logic signed [twva_pkg::ANG_W-1:0] i_right_angle,
    input  logic signed [twva_pkg::SPD_W-1:0] i_right_speed,
    input  logic signed [twva_pkg::ANG_W-1:0] i_back_angle,
    input  logic signed [twva_pkg::SPD_W-1:0] i_back_speed,
    input  logic                              i_empty,
    input  logic                              i_pop,
    input  logic signed [twva_pkg::HDG_W-1:0] i_heading_deg,
    input  logic [twva_pkg::MAG_W-1:0]        i_magnitude,
    output int                                o_errors,
    output int                                o_pending,
    output int                                o_checked
);
    import twva_pkg::*;

    typedef struct {
        logic signed [HDG_W-1:0] heading;
        logic [MAG_W-1:0]        magnitude;
    } t_heading_mag;

    t_heading_mag mean_q[$];

    function automatic int n_steps();
        return (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    endfunction

    // Rotation-mode pass: (speed, 0) turned by the wheel angle, gain kept.
    function automatic void wheel_to_xy(input logic signed [ANG_W-1:0] ang,
                                        input logic signed [SPD_W-1:0] spd,
                                        output longint px, output longint py);
        longint a, z, x, y, dx, dy;
        a = ang;
        if (a > longint'(ANG_SAT)) a = ANG_SAT;
        if (a < -longint'(ANG_SAT)) a = -longint'(ANG_SAT);
        z = a * 128;
        x = longint'(spd) * 256;
        y = 0;
        if (z > longint'(HALF_PI_INT)) begin
            z -= PI_INT;
            x = -x;
        end else if (z < -longint'(HALF_PI_INT)) begin
            z += PI_INT;
            x = -x;
        end
        for (int i = 0; i < n_steps(); i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab(i);
            end else begin
                x += dx; y -= dy; z += atan_tab(i);
            end
        end
        px = x;
        py = y;
    endfunction

    function automatic t_heading_mag mean_heading(input longint sx, input longint sy);
        t_heading_mag r;
        longint x, y, z, dx, dy, p, h;
        longint unsigned ux, m, den;
        r.heading = '0;
        r.magnitude = '0;
        if (sx == 0 && sy == 0) return r;
        x = sx; y = sy; z = 0;
        if (x < 0) begin
            z = (y >= 0) ? longint'(PI_INT) : -longint'(PI_INT);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < n_steps(); i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_tab(i);
            end else begin
                x -= dx; y += dy; z -= atan_tab(i);
            end
        end
        p = z * HDG_MAX;
        if (p >= 0) h = (p + longint'(PI_INT) / 2) / longint'(PI_INT);
        else h = -((-p + longint'(PI_INT) / 2) / longint'(PI_INT));
        if (h > HDG_MAX) h = HDG_MAX;
        if (h < -HDG_MAX) h = -HDG_MAX;
        ux = (x > 0) ? longint'(x) : 0;
        den = 64'd3 << 38;
        m = (ux * longint'(KSQ_Q30) + den / 2) / den;
        if (m > MAG_MAX) m = MAG_MAX;
        r.heading = h[HDG_W-1:0];
        r.magnitude = m[MAG_W-1:0];
        return r;
    endfunction

    assign o_pending = mean_q.size();

    always @(posedge i_clk) begin
        longint px, py, sx, sy;
        t_heading_mag want;
        if (!i_rst_n) begin
            mean_q.delete();
            o_errors <= 0;
            o_checked <= 0;
        end else begin
            if (i_push && !i_full) begin
                wheel_to_xy(i_left_angle, i_left_speed, px, py);
                sx = px; sy = py;
                wheel_to_xy(i_right_angle, i_right_speed, px, py);
                sx += px; sy += py;
                wheel_to_xy(i_back_angle, i_back_speed, px, py);
                sx += px; sy += py;
                mean_q.push_back(mean_heading(sx, sy));
            end
            if (i_pop && !i_empty) begin
                o_checked <= o_checked + 1;
                if (mean_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: unexpected word hdg=%0d mag=%0d", $realtime,
                                 i_heading_deg, i_magnitude);
                    o_errors <= o_errors + 1;
                end else begin
                    want = mean_q.pop_front();
                    if (want.heading !== i_heading_deg || want.magnitude !== i_magnitude) begin
                        if (o_errors < 10)
                            $display("%0t: mismatch hdg exp %0d got %0d, mag exp %0d got %0d",
                                     $realtime, want.heading, i_heading_deg,
                                     want.magnitude, i_magnitude);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives wheel sets into the vector averager with random gaps, drains the
// result queue with random stalls and one long hold-off, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import twva_pkg::*;

    localparam int STEPS   = CORDIC_STEPS_DEF;
    localparam int LATENCY = 2 * STEPS + 6;
    localparam int N_RAND  = 700;

    logic i_clk, i_rst_n, push, full, empty, pop;
    logic signed [ANG_W-1:0] la, ra, ba;
    logic signed [SPD_W-1:0] ls, rs, bs;
    logic signed [HDG_W-1:0] hdg;
    logic [MAG_W-1:0] mag;
    int errors, pending, checked;
    bit burst;      // when set, neither side idles
    bit stim_done;

    three_wheel_vector_average_top #(.CORDIC_STEPS(STEPS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_left_angle(la), .i_left_speed(ls), .i_right_angle(ra),
        .i_right_speed(rs), .i_back_angle(ba), .i_back_speed(bs),
        .empty(empty), .pop(pop), .o_heading_deg(hdg), .o_magnitude(mag)
    );

    twva_checker #(.CORDIC_STEPS(STEPS)) u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full),
        .i_left_angle(la), .i_left_speed(ls), .i_right_angle(ra),
        .i_right_speed(rs), .i_back_angle(ba), .i_back_speed(bs),
        .i_empty(empty), .i_pop(pop), .i_heading_deg(hdg), .i_magnitude(mag),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // One wheel set: optional gap, then hold push until the block takes the word.
    task automatic send_set(input logic signed [ANG_W-1:0] a0, input logic signed [SPD_W-1:0] s0,
                            input logic signed [ANG_W-1:0] a1, input logic signed [SPD_W-1:0] s1,
                            input logic signed [ANG_W-1:0] a2, input logic signed [SPD_W-1:0] s2);
        int gap;
        gap = burst ? 0 : $urandom_range(16);
        if (gap > 0) begin
            push <= 0;
            repeat (gap) @(posedge i_clk);
        end
        la <= a0; ls <= s0; ra <= a1; rs <= s1; ba <= a2; bs <= s2;
        push <= 1;
        do @(posedge i_clk); while (full);
    endtask

    // Mostly in-range angles; a few past pi to hit saturation.
    function automatic logic signed [ANG_W-1:0] rand_angle();
        if ($urandom_range(9) == 0) return ANG_W'($urandom);
        return ANG_W'($signed($urandom_range(2 * 25736)) - 25736);
    endfunction

    function automatic logic signed [SPD_W-1:0] rand_speed();
        case ($urandom_range(3))
            0: return SPD_W'($signed($urandom_range(1024)) - 512);   // slow wheels
            default: return SPD_W'($urandom);
        endcase
    endfunction

    // Stimulus
    initial begin
        i_rst_n = 0; push = 0; burst = 0; stim_done = 0;
        la = 0; ls = 0; ra = 0; rs = 0; ba = 0; bs = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed corners
        send_set(0, 0, 0, 0, 0, 0);                         // all stopped: zero mean
        send_set(0, 256, 0, -256, 0, 0);                    // cancelling wheels: zero mean
        send_set(0, -256, 0, 0, 0, 0);                      // mean on -x axis
        send_set(25736, 256, 25736, 256, 25736, 256);       // all at +pi
        send_set(-25736, 256, -25736, 256, -25736, 256);    // all at -pi
        send_set(16'sh7FFF, 100, 16'sh8000, 100, 30000, 100); // saturated angles
        send_set(12867, 512, 12868, 512, -12868, 512);      // either side of pi/2 fold
        send_set(-12867, 512, 0, 32767, 0, 32767);
        send_set(0, 32767, 0, 32767, 0, 32767);             // max forward speed
        send_set(0, -32768, 0, -32768, 0, -32768);          // max reverse speed
        send_set(12868, 32767, 12868, 32767, 12868, 32767); // straight up, full speed
        send_set(-12868, -32768, 25736, 32767, 0, -32768);
        send_set(6434, 1, -6434, 1, 0, 1);                  // tiny speeds
        send_set(0, 1, 0, 0, 0, 0);
        send_set(25736, -1, -25736, 1, 0, 0);
        send_set(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 0, 16'sh7F00);

        for (int i = 0; i < N_RAND; i++) begin
            if (i % 100 == 50) burst = ~burst;
            send_set(rand_angle(), rand_speed(), rand_angle(), rand_speed(),
                     rand_angle(), rand_speed());
        end
        push <= 0;
        stim_done = 1;
    end

    // Result drain: random stalls, plus one long hold-off so the block backs up.
    initial begin
        int gap;
        bit held;
        pop = 0;
        held = 0;
        @(posedge i_rst_n);
        forever begin
            gap = burst ? 0 : $urandom_range(16);
            if (!held && checked >= 200) begin
                gap = 400;
                held = 1;
            end
            if (gap > 0) begin
                pop <= 0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1;
            do @(posedge i_clk); while (empty);
        end
    end

    // Verdict
    initial begin
        int guard;
        wait (stim_done);
        guard = 0;
        while (pending != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("Checked %0d words: directed corners plus %0d random wheel sets,", checked, N_RAND);
        $display("with random gaps on both sides and one long drain stall.");
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #(20 * 400000);
        $display("== FAIL ==");
        $finish;
    end
endmodule
